// File: hdl/hpct_pkg.sv
// Shared types and constants for the hot page counter table.
// No dependencies; every other file of the block but hpct_chk uses this package.
package hpct_pkg;
    localparam int NUM_SETS_DEF = 4;
    localparam int NUM_WAYS_DEF = 64;
    localparam int PAGE_W = 40;
    localparam int TIME_W = 64;
    localparam int CNT_W = 8;
    localparam int SLOT_W = 8;
    localparam logic [CNT_W-1:0] THR_RESET = 8'd3;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MOD   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_UPD   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic mod_step;
        logic scan_step;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic mod_done;
        logic scan_done;
        logic zero_page;
    } t_sts;

    typedef struct packed {
        logic [PAGE_W-1:0] tag;
        logic [CNT_W-1:0]  cnt;
        logic [TIME_W-1:0] acc_time;
        logic              reported;
    } t_slot;
endpackage

// File: hdl/hpct_in_if.sv
// Request channel carrying one page access.
// Depends on hpct_pkg for field widths.
interface hpct_in_if;
    logic                          valid;
    logic                          ready;
    logic [hpct_pkg::PAGE_W-1:0]   page_number;
    logic [hpct_pkg::TIME_W-1:0]   timestamp;
    modport source (output valid, page_number, timestamp, input ready);
    modport sink (input valid, page_number, timestamp, output ready);
endinterface

// File: hdl/hpct_res_if.sv
// Result channel carrying one lookup outcome.
// Depends on hpct_pkg for field widths.
interface hpct_res_if;
    logic                          valid;
    logic                          ready;
    logic                          hot_report;
    logic                          was_hit;
    logic [hpct_pkg::SLOT_W-1:0]   slot_index;
    modport source (output valid, hot_report, was_hit, slot_index, input ready);
    modport sink (input valid, hot_report, was_hit, slot_index, output ready);
endinterface

// File: hdl/hpct_cfg_if.sv
// Configuration write channel for the hot threshold register.
// Depends on hpct_pkg for the register width.
interface hpct_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [hpct_pkg::CNT_W-1:0]    data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// File: hdl/hot_page_counter_table_top.sv
// Top level of the hot page counter table: controller plus datapath.
// Depends on hpct_pkg, hpct_ctrl, hpct_dp and the three channel interfaces.
//
//  channel  | direction | payload
//  i_req    | in        | page_number, timestamp
//  o_res    | out       | hot_report, was_hit, slot_index
//  i_cfg    | in        | data (hot threshold)
//
// A request computes the set residue, scans the set through the single slot
// memory read port, and then updates one slot; a request for page zero skips
// the scan and writes no slot.
// After reset a clearing pass writes all NUM_SETS * NUM_WAYS slots, one per
// cycle, before the first request is accepted; configuration is always taken.
// The result is held until taken; the next request waits for that.
module hot_page_counter_table_top #(
    parameter int NUM_SETS = hpct_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS = hpct_pkg::NUM_WAYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hpct_in_if.sink     i_req,
    hpct_res_if.source  o_res,
    hpct_cfg_if.sink    i_cfg
);
    hpct_pkg::t_cmd cmd;
    hpct_pkg::t_sts sts;

    assign i_cfg.ready = 1'b1;

    hpct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    hpct_dp #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_page     (i_req.page_number),
        .i_time     (i_req.timestamp),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .o_hot      (o_res.hot_report),
        .o_hit      (o_res.was_hit),
        .o_slot     (o_res.slot_index)
    );
endmodule

// File: hdl/hpct_ctrl.sv
// Sequencing state machine of the hot page counter table.
// Depends on hpct_pkg for state, command and status types.
module hpct_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    input  hpct_pkg::t_sts  i_sts,
    output hpct_pkg::t_cmd  o_cmd
);
    hpct_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hpct_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            hpct_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = hpct_pkg::S_IDLE;
            end
            hpct_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = hpct_pkg::S_MOD;
                end
            end
            hpct_pkg::S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_done) begin
                    n_state = i_sts.zero_page ? hpct_pkg::S_UPD : hpct_pkg::S_SCAN;
                end
            end
            hpct_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) n_state = hpct_pkg::S_UPD;
            end
            hpct_pkg::S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = hpct_pkg::S_OUT;
            end
            hpct_pkg::S_OUT: begin
                if (i_out_ready) n_state = hpct_pkg::S_IDLE;
            end
            default: n_state = hpct_pkg::S_CLEAR;
        endcase
    end

    assign o_in_ready = (r_state == hpct_pkg::S_IDLE);
    assign o_out_valid = (r_state == hpct_pkg::S_OUT);
endmodule

// File: hdl/hpct_dp.sv
// Datapath: slot memory, set residue, way scan and update of the table.
// Depends on hpct_pkg for widths, command, status and slot types.
module hpct_dp #(
    parameter int NUM_SETS = hpct_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS = hpct_pkg::NUM_WAYS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hpct_pkg::t_cmd               i_cmd,
    output hpct_pkg::t_sts               o_sts,
    input  logic [hpct_pkg::PAGE_W-1:0]  i_page,
    input  logic [hpct_pkg::TIME_W-1:0]  i_time,
    input  logic                         i_cfg_we,
    input  logic [hpct_pkg::CNT_W-1:0]   i_cfg_data,
    output logic                         o_hot,
    output logic                         o_hit,
    output logic [hpct_pkg::SLOT_W-1:0]  o_slot
);
    localparam int SLOTS = NUM_SETS * NUM_WAYS;
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WW = $clog2(NUM_WAYS);
    localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int PW = hpct_pkg::PAGE_W;
    localparam int CW = hpct_pkg::CNT_W;
    localparam int TW = hpct_pkg::TIME_W;
    localparam int NIB = PW / 4;
    localparam int FW = 12;
    localparam int RECIP = ((1 << 16) + NUM_SETS - 1) / NUM_SETS;

    function automatic int nib_weight(input int pos);
        int w;
        w = 1 % NUM_SETS;
        for (int k = 0; k < pos; k++) w = (w * 16) % NUM_SETS;
        return w;
    endfunction

    hpct_pkg::t_slot mem [SLOTS];
    hpct_pkg::t_slot r_rd;

    logic [CW-1:0]                  r_thr;
    logic [AW-1:0]                  r_clr_addr;
    logic [PW-1:0]                  r_page;
    logic [TW-1:0]                  r_time;
    logic [SW-1:0]                  r_res;
    logic [FW-1:0]                  r_fold;
    logic                           r_mod_ph;
    logic [WW:0]                    r_rd_way;
    logic                           r_cmp_vld;
    logic [WW-1:0]                  r_cmp_way;
    logic                           r_hit, r_emp;
    logic [WW-1:0]                  r_hit_way, r_emp_way, r_old_way;
    logic [CW-1:0]                  r_hit_cnt;
    logic                           r_hit_rep;
    logic [TW-1:0]                  r_old_time;
    logic                           r_hot, r_was_hit;
    logic [AW-1:0]                  r_slot;

    logic [FW-1:0]                  nib_term [NIB];
    logic [FW-1:0]                  n_fold;
    logic [FW+16:0]                 mod_prod;
    logic [FW-1:0]                  mod_q, mod_rem;
    logic [AW-1:0]                  base, rd_addr, wr_addr;
    logic [WW-1:0]                  upd_way;
    logic [CW-1:0]                  upd_cnt;
    logic                           upd_rep;
    hpct_pkg::t_slot                wr_data;
    logic                           wr_en;

    // Each nibble is weighted by its power of sixteen taken modulo the set count.
    for (genvar g = 0; g < NIB; g++) begin : g_fold
        localparam int WGT = nib_weight(g);
        assign nib_term[g] = FW'(r_page[4*g +: 4]) * FW'(WGT);
    end

    always_comb begin
        n_fold = '0;
        for (int k = 0; k < NIB; k++) n_fold = n_fold + nib_term[k];
    end

    always_comb begin
        mod_prod = (FW+17)'(r_fold) * (FW+17)'(RECIP);
        mod_q = mod_prod[16 +: FW];
        mod_rem = r_fold - mod_q * FW'(NUM_SETS);
    end

    assign base = AW'(r_res) * AW'(NUM_WAYS);
    assign rd_addr = base + AW'(r_rd_way[WW-1:0]);
    assign upd_way = r_hit ? r_hit_way : (r_emp ? r_emp_way : r_old_way);
    assign upd_cnt = (r_hit_cnt < r_thr) ? r_hit_cnt + 1'b1 : r_hit_cnt;
    assign upd_rep = (upd_cnt >= r_thr) && !r_hit_rep;

    always_comb begin
        wr_en = 1'b0;
        wr_addr = base + AW'(upd_way);
        wr_data = '0;
        if (i_cmd.clr_step) begin
            wr_en = 1'b1;
            wr_addr = r_clr_addr;
        end else if (i_cmd.update && r_page != '0) begin
            wr_en = 1'b1;
            wr_data.tag = r_page;
            wr_data.acc_time = r_time;
            wr_data.cnt = r_hit ? upd_cnt : CW'(1);
            wr_data.reported = r_hit && (r_hit_rep || upd_rep);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= hpct_pkg::THR_RESET;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) r_thr <= i_cfg_data;
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= i_page;
            r_time <= i_time;
            r_mod_ph <= 1'b0;
        end
        if (i_cmd.mod_step) begin
            if (!r_mod_ph) begin
                r_fold <= n_fold;
                r_mod_ph <= 1'b1;
            end else begin
                r_res <= SW'(mod_rem);
            end
            r_rd_way <= '0;
            r_cmp_vld <= 1'b0;
            r_hit <= 1'b0;
            r_emp <= 1'b0;
        end
        if (i_cmd.scan_step) begin
            if (r_rd_way < (WW+1)'(NUM_WAYS)) begin
                r_cmp_vld <= 1'b1;
                r_cmp_way <= r_rd_way[WW-1:0];
                r_rd_way <= r_rd_way + 1'b1;
            end else begin
                r_cmp_vld <= 1'b0;
            end
            if (r_cmp_vld) begin
                if (!r_hit && r_rd.tag == r_page) begin
                    r_hit <= 1'b1;
                    r_hit_way <= r_cmp_way;
                    r_hit_cnt <= r_rd.cnt;
                    r_hit_rep <= r_rd.reported;
                end
                if (!r_emp && r_rd.tag == '0) begin
                    r_emp <= 1'b1;
                    r_emp_way <= r_cmp_way;
                end
                if (r_cmp_way == '0 || r_rd.acc_time < r_old_time) begin
                    r_old_time <= r_rd.acc_time;
                    r_old_way <= r_cmp_way;
                end
            end
        end
        if (i_cmd.update) begin
            if (r_page == '0) begin
                r_hot <= 1'b0;
                r_was_hit <= 1'b0;
                r_slot <= '0;
            end else begin
                r_hot <= r_hit && upd_rep;
                r_was_hit <= r_hit;
                r_slot <= base + AW'(upd_way);
            end
        end
    end

    assign o_sts.clr_done = (r_clr_addr == AW'(SLOTS - 1));
    assign o_sts.mod_done = r_mod_ph;
    assign o_sts.scan_done = r_cmp_vld && (r_cmp_way == WW'(NUM_WAYS - 1));
    assign o_sts.zero_page = (r_page == '0);
    assign o_hot = r_hot;
    assign o_hit = r_was_hit;
    assign o_slot = hpct_pkg::SLOT_W'(r_slot);
endmodule

// File: hdl/hpct_chk.sv
// Port-level checker for the hot page counter table, bound to the top level.
// Depends only on the top level's channel signals.
module hpct_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_hot,
    input logic i_hit
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid) else $error("result dropped");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready) else $error("second request taken");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready) else $error("request taken while result pending");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_out_valid) else $error("result too early");
    a_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_hot |-> i_hit) else $error("report without hit");
endmodule

bind hot_page_counter_table_top hpct_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_hot       (o_res.hot_report),
    .i_hit       (o_res.was_hit)
);

// File: tb/hpct_checker.sv
// Scoreboard for the hot page counter table: watches the request, result and
// configuration channels, predicts each lookup outcome and compares it.
// Depends on hpct_pkg and the three channel interfaces.
`timescale 1ns / 100ps
module hpct_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    hpct_in_if   req,
    hpct_res_if  res,
    hpct_cfg_if  cfg,
    output int   o_errors,
    output int   o_pending
);
    localparam int SETS = hpct_pkg::NUM_SETS_DEF;
    localparam int WAYS = hpct_pkg::NUM_WAYS_DEF;
    localparam int SLOTS = SETS * WAYS;

    typedef struct packed {
        logic                        hot_report;
        logic                        was_hit;
        logic [hpct_pkg::SLOT_W-1:0] slot_index;
    } t_outcome;

    logic [hpct_pkg::PAGE_W-1:0] tag_mem [SLOTS];
    logic [hpct_pkg::CNT_W-1:0]  count_mem [SLOTS];
    logic [hpct_pkg::TIME_W-1:0] time_mem [SLOTS];
    logic                        reported_mem [SLOTS];
    logic [hpct_pkg::CNT_W-1:0]  threshold;
    t_outcome                    outcome_q [$];

    function automatic t_outcome lookup_page(logic [hpct_pkg::PAGE_W-1:0] page,
                                             logic [hpct_pkg::TIME_W-1:0] stamp);
        t_outcome o;
        int base;
        int hit_way;
        int empty_way;
        int old_way;
        int slot;
        logic [hpct_pkg::TIME_W-1:0] old_time;
        o = '0;
        if (page == '0) begin
            return o;
        end
        base = int'(page % SETS) * WAYS;
        hit_way = -1;
        empty_way = -1;
        old_way = 0;
        old_time = time_mem[base];
        for (int w = 0; w < WAYS; w++) begin
            if (hit_way < 0 && tag_mem[base + w] == page) hit_way = w;
            if (empty_way < 0 && tag_mem[base + w] == '0) empty_way = w;
            if (time_mem[base + w] < old_time) begin
                old_time = time_mem[base + w];
                old_way = w;
            end
        end
        if (hit_way >= 0) begin
            slot = base + hit_way;
            if (count_mem[slot] < threshold) count_mem[slot] = count_mem[slot] + 1'b1;
            time_mem[slot] = stamp;
            if (count_mem[slot] >= threshold && !reported_mem[slot]) begin
                reported_mem[slot] = 1'b1;
                o.hot_report = 1'b1;
            end
            o.was_hit = 1'b1;
        end else begin
            slot = base + ((empty_way >= 0) ? empty_way : old_way);
            tag_mem[slot] = page;
            count_mem[slot] = hpct_pkg::CNT_W'(1);
            time_mem[slot] = stamp;
            reported_mem[slot] = 1'b0;
        end
        o.slot_index = slot[hpct_pkg::SLOT_W-1:0];
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_outcome exp_o;
        int err_cnt;
        err_cnt = 0;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                tag_mem[s] = '0;
                count_mem[s] = '0;
                time_mem[s] = '0;
                reported_mem[s] = 1'b0;
            end
            threshold = hpct_pkg::THR_RESET;
            outcome_q.delete();
            o_errors <= 0;
        end else begin
            if (cfg.valid && cfg.ready) threshold = cfg.data;
            if (req.valid && req.ready) begin
                outcome_q.push_back(lookup_page(req.page_number, req.timestamp));
            end
            if (res.valid && res.ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result with no request outstanding");
                    err_cnt = err_cnt + 1;
                end else begin
                    exp_o = outcome_q.pop_front();
                    if (res.hot_report !== exp_o.hot_report) begin
                        $error("hot_report: expected %0d, got %0d",
                               exp_o.hot_report, res.hot_report);
                        err_cnt = err_cnt + 1;
                    end
                    if (res.was_hit !== exp_o.was_hit) begin
                        $error("was_hit: expected %0d, got %0d",
                               exp_o.was_hit, res.was_hit);
                        err_cnt = err_cnt + 1;
                    end
                    if (res.slot_index !== exp_o.slot_index) begin
                        $error("slot_index: expected %0d, got %0d",
                               exp_o.slot_index, res.slot_index);
                        err_cnt = err_cnt + 1;
                    end
                end
            end
            o_errors <= o_errors + err_cnt;
        end
        o_pending <= outcome_q.size();
    end
endmodule

// File: tb/tb_top.sv
// Top of the hot page counter table testbench: clock, reset, access stimulus,
// threshold writes and the verdict. Depends on hpct_pkg, the channel
// interfaces, hpct_checker and hot_page_counter_table_top.
`timescale 1ns / 100ps
module tb_top;
    localparam int PHASE_ITEMS = 205;
    localparam int POOL_SIZE = 96;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_cycles;
    logic hold_go;
    logic [hpct_pkg::TIME_W-1:0] now_ts;
    logic [hpct_pkg::PAGE_W-1:0] page_pool [POOL_SIZE];

    hpct_in_if  req_if ();
    hpct_res_if res_if ();
    hpct_cfg_if cfg_if ();

    hot_page_counter_table_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    hpct_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .req       (req_if),
        .res       (res_if),
        .cfg       (cfg_if),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_cycles <= 0;
        end else if (hold_go) begin
            res_if.ready <= 1'b0;
            hold_cycles <= 600;
        end else if (hold_cycles > 0) begin
            res_if.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_access(logic [hpct_pkg::PAGE_W-1:0] page,
                               logic [hpct_pkg::TIME_W-1:0] stamp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.page_number <= page;
        req_if.timestamp <= stamp;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic drain_requests();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [hpct_pkg::CNT_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_access();
        logic [hpct_pkg::PAGE_W-1:0] page;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 58) page = page_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 96) page = {8'($urandom_range(0, 255)), $urandom};
        else page = '0;
        if ($urandom_range(0, 9) == 0) now_ts = {$urandom, $urandom};
        else now_ts = now_ts + $urandom_range(0, 3);
        send_access(page, now_ts);
    endtask

    initial begin
        logic [hpct_pkg::CNT_W-1:0] thr_plan [6];
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.page_number = '0;
        req_if.timestamp = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        hold_go = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        now_ts = '0;
        thr_plan = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd7, 8'd3};
        for (int p = 0; p < POOL_SIZE; p++) begin
            page_pool[p] = {8'($urandom_range(0, 255)), $urandom} | 40'd1;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_access(40'd1, 64'd0);
        send_access(40'hFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(40'd0, 64'd5);
        for (int k = 0; k < 5; k++) send_access(40'd1, 64'd10 + k);
        for (int k = 0; k < 4; k++) send_access(40'hFF_FFFF_FFFF, 64'd20);
        send_access(40'hAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_access(40'h55_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        for (int k = 0; k < 66; k++) send_access(40'd4 * k + 8, 64'd100 + k % 3);
        send_access(40'd8, 64'd200);
        now_ts = 64'd1000;
        drain_requests();

        for (int ph = 0; ph < 6; ph++) begin
            write_threshold(thr_plan[ph]);
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 54 : 18) : 0;
            recv_stall_pct = (ph % 4 == 2) ? 54 : ((ph % 4 == 3) ? 18 : 0);
            if (ph == 0) begin
                hold_go <= 1'b1;
                @(posedge i_clk);
                hold_go <= 1'b0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) random_access();
            drain_requests();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
